@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high
`define CMM_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cmm assertion failed");

// Concurrent check that also holds across reset
`define CMM_ASSERT_NR(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("cmm assertion failed");

`endif

@@ sv/cmm_pkg.sv @@
// ---------------------------------------------------------------------------
// cmm_pkg
// Types, sizes and helpers of the complex matrix multiply unit.
// ---------------------------------------------------------------------------
package cmm_pkg;

   localparam int MAX_DIM         = 8;
   localparam int DATA_WIDTH      = 16;
   localparam int ACC_WIDTH       = 36;
   localparam int ELEM_WIDTH      = 2 * DATA_WIDTH;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int STORE_DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH      = $clog2(STORE_DEPTH);
   localparam int CNT_WIDTH       = ADDR_WIDTH + 1;
   localparam int IDX_WIDTH       = $clog2(MAX_DIM);
   localparam int DIM_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD_A = 1'b0,
      FUNC_LOAD_B = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_MAC,
      SEQ_DRAIN
   } seq_state_type;

   // Control that travels with one beat through the MAC pipeline
   typedef struct packed {
      logic valid;
      logic first_k;
      logic emit;
      logic drain;
      logic last;
   } beat_ctrl_type;

   // Zero acts as one, anything above MAX_DIM acts as MAX_DIM
   function automatic logic [DIM_WIDTH-1:0] eff_dim(input logic [DIM_WIDTH-1:0] d);
      logic [DIM_WIDTH-1:0] r;
      if (d == '0) r = DIM_WIDTH'(1);
      else if (d > DIM_WIDTH'(MAX_DIM)) r = DIM_WIDTH'(MAX_DIM);
      else r = d;
      return r;
   endfunction

endpackage

@@ sv/cmm_req_if.sv @@
// ---------------------------------------------------------------------------
// cmm_req_if
// Element load channel: selector plus one complex Q8.8 element per beat.
// ---------------------------------------------------------------------------
interface cmm_req_if import cmm_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic signed [DATA_WIDTH-1:0]  real_in;
   logic signed [DATA_WIDTH-1:0]  imag_in;

   modport source (output valid, func, real_in, imag_in, input ready);
   modport sink   (input valid, func, real_in, imag_in, output ready);
endinterface

@@ sv/cmm_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cmm_rsp_if
// Product channel: one complex Q20.16 product entry per beat.
// ---------------------------------------------------------------------------
interface cmm_rsp_if import cmm_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [ACC_WIDTH-1:0]  real_out;
   logic signed [ACC_WIDTH-1:0]  imag_out;
   logic                         last;

   modport source (output valid, real_out, imag_out, last, input ready);
   modport sink   (input valid, real_out, imag_out, last, output ready);
endinterface

@@ sv/cmm_ram.sv @@
// ---------------------------------------------------------------------------
// cmm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/cmm_cell.sv @@
// ---------------------------------------------------------------------------
// cmm_cell
// One accumulator cell of the ring: loads its source plus a term.
// ---------------------------------------------------------------------------
module cmm_cell import cmm_pkg::*; (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [ACC_WIDTH-1:0] src_re,
   input  logic signed [ACC_WIDTH-1:0] src_im,
   input  logic signed [ACC_WIDTH-1:0] term_re,
   input  logic signed [ACC_WIDTH-1:0] term_im,
   output logic signed [ACC_WIDTH-1:0] acc_re,
   output logic signed [ACC_WIDTH-1:0] acc_im
);

   logic signed [ACC_WIDTH-1:0] acc_re_ff, acc_re_in;
   logic signed [ACC_WIDTH-1:0] acc_im_ff, acc_im_in;

   // Sum wraps at the accumulator width, which never overflows here
   always_comb begin
      acc_re_in = src_re + term_re;
      acc_im_in = src_im + term_im;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

@@ sv/cmm_chain.sv @@
// ---------------------------------------------------------------------------
// cmm_chain
// Product stage and ring of accumulator cells, one cell per product column.
// ---------------------------------------------------------------------------
module cmm_chain import cmm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  beat_ctrl_type               ctrl_s0,
   input  logic [ELEM_WIDTH-1:0]       a_elem,
   input  logic [ELEM_WIDTH-1:0]       b_elem,
   input  logic [DIM_WIDTH-1:0]        p_dim,
   output beat_ctrl_type               ctrl_s2,
   output logic signed [ACC_WIDTH-1:0] tail_re,
   output logic signed [ACC_WIDTH-1:0] tail_im
);

   beat_ctrl_type ctrl_s1_ff, ctrl_s2_ff;

   logic signed [DATA_WIDTH-1:0] a_re, a_im, b_re, b_im;
   logic signed [PROD_WIDTH-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [PROD_WIDTH-1:0] rr_in, ii_in, ri_in, ir_in;

   logic signed [ACC_WIDTH-1:0] cell_re [MAX_DIM];
   logic signed [ACC_WIDTH-1:0] cell_im [MAX_DIM];
   logic signed [ACC_WIDTH-1:0] src_re  [MAX_DIM];
   logic signed [ACC_WIDTH-1:0] src_im  [MAX_DIM];
   logic signed [ACC_WIDTH-1:0] term_re [MAX_DIM];
   logic signed [ACC_WIDTH-1:0] term_im [MAX_DIM];
   logic [IDX_WIDTH-1:0]        tail_idx;
   logic                        shift;

   // Beat control follows the RAM read and the product register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s1_ff <= '0;
         ctrl_s2_ff <= '0;
      end else if (en) begin
         ctrl_s1_ff <= ctrl_s0;
         ctrl_s2_ff <= ctrl_s1_ff;
      end
   end

   // Four partial products of the complex multiply
   always_comb begin
      a_re  = a_elem[ELEM_WIDTH-1:DATA_WIDTH];
      a_im  = a_elem[DATA_WIDTH-1:0];
      b_re  = b_elem[ELEM_WIDTH-1:DATA_WIDTH];
      b_im  = b_elem[DATA_WIDTH-1:0];
      rr_in = a_re * b_re;
      ii_in = a_im * b_im;
      ri_in = a_re * b_im;
      ir_in = a_im * b_re;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
         ir_ff <= ir_in;
      end
   end

   // Ring closes at column p-1; the head restarts at zero on the first k and in the drain pass
   assign tail_idx = IDX_WIDTH'(p_dim - DIM_WIDTH'(1));
   assign tail_re  = cell_re[tail_idx];
   assign tail_im  = cell_im[tail_idx];
   assign shift    = en && ctrl_s2_ff.valid;

   always_comb begin
      for (int x = 0; x < MAX_DIM; x++) begin
         if (x == 0) begin
            src_re[x]  = (ctrl_s2_ff.first_k || ctrl_s2_ff.drain) ? '0 : tail_re;
            src_im[x]  = (ctrl_s2_ff.first_k || ctrl_s2_ff.drain) ? '0 : tail_im;
            term_re[x] = ACC_WIDTH'(rr_ff) - ACC_WIDTH'(ii_ff);
            term_im[x] = ACC_WIDTH'(ri_ff) + ACC_WIDTH'(ir_ff);
         end else begin
            src_re[x]  = cell_re[x-1];
            src_im[x]  = cell_im[x-1];
            term_re[x] = '0;
            term_im[x] = '0;
         end
      end
   end

   for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
      cmm_cell u_cell (
         .clock   (clock),
         .en      (shift),
         .src_re  (src_re[g]),
         .src_im  (src_im[g]),
         .term_re (term_re[g]),
         .term_im (term_im[g]),
         .acc_re  (cell_re[g]),
         .acc_im  (cell_im[g])
      );
   end

   assign ctrl_s2 = ctrl_s2_ff;

endmodule

@@ sv/cmm_seq.sv @@
// ---------------------------------------------------------------------------
// cmm_seq
// Walks rows, inner index and columns (columns innermost), then one drain pass.
// ---------------------------------------------------------------------------
module cmm_seq import cmm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  en,
   input  logic [DIM_WIDTH-1:0]  m_dim,
   input  logic [DIM_WIDTH-1:0]  n_dim,
   input  logic [DIM_WIDTH-1:0]  p_dim,
   output logic [ADDR_WIDTH-1:0] a_addr,
   output logic [ADDR_WIDTH-1:0] b_addr,
   output beat_ctrl_type         ctrl,
   output logic                  busy
);

   seq_state_type state_ff, state_in;
   logic [IDX_WIDTH-1:0] i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic [IDX_WIDTH-1:0] m_last, n_last, p_last;
   logic [CNT_WIDTH-1:0] a_lin, b_lin;

   assign m_last = IDX_WIDTH'(m_dim - DIM_WIDTH'(1));
   assign n_last = IDX_WIDTH'(n_dim - DIM_WIDTH'(1));
   assign p_last = IDX_WIDTH'(p_dim - DIM_WIDTH'(1));

   // Row-major store addresses of A(i,k) and B(k,j)
   assign a_lin  = CNT_WIDTH'(i_ff) * CNT_WIDTH'(n_dim) + CNT_WIDTH'(k_ff);
   assign b_lin  = CNT_WIDTH'(k_ff) * CNT_WIDTH'(p_dim) + CNT_WIDTH'(j_ff);
   assign a_addr = a_lin[ADDR_WIDTH-1:0];
   assign b_addr = b_lin[ADDR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         i_ff     <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
      end
   end

   // Next state and beat control
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      ctrl     = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_MAC;
               i_in     = '0;
               k_in     = '0;
               j_in     = '0;
            end
         end
         SEQ_MAC: begin
            ctrl.valid   = 1'b1;
            ctrl.first_k = (k_ff == '0);
            ctrl.emit    = (k_ff == '0) && (i_ff != '0);
            if (en) begin
               if (j_ff != p_last) begin
                  j_in = j_ff + IDX_WIDTH'(1);
               end else begin
                  j_in = '0;
                  if (k_ff != n_last) begin
                     k_in = k_ff + IDX_WIDTH'(1);
                  end else begin
                     k_in = '0;
                     if (i_ff != m_last) i_in = i_ff + IDX_WIDTH'(1);
                     else state_in = SEQ_DRAIN;
                  end
               end
            end
         end
         SEQ_DRAIN: begin
            ctrl.valid = 1'b1;
            ctrl.emit  = 1'b1;
            ctrl.drain = 1'b1;
            ctrl.last  = (j_ff == p_last);
            if (en) begin
               if (j_ff != p_last) j_in = j_ff + IDX_WIDTH'(1);
               else begin
                  j_in     = '0;
                  state_in = SEQ_IDLE;
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign busy = (state_ff != SEQ_IDLE);

endmodule

@@ sv/complex_matrix_multiply_unit.sv @@
// A round starts on the B beat that completes the B store, with one complex
// multiply-accumulate per cycle, while the output does not stall, in the head
// cell of the column ring.
// Load beats are taken one per cycle while no product is being sequenced.
// Reset (synchronous) clears counts and pipeline, sets sizes to 8; the
// element stores are not cleared.
// ---------------------------------------------------------------------------
// complex_matrix_multiply_unit
// Loads complex A and B elements and streams the exact complex product.
// ---------------------------------------------------------------------------
module complex_matrix_multiply_unit import cmm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   cmm_req_if.sink                    req_chan,
   cmm_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DIM_WIDTH-1:0]       csr_wr_data
);

   logic [DIM_WIDTH-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_WIDTH-1:0] m_dim, n_dim, p_dim;
   logic [CNT_WIDTH-1:0] a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic [CNT_WIDTH-1:0] mn, np, b_idx, b_next;
   logic                 accept, a_wr, b_wr, trigger, busy, en;
   logic [ELEM_WIDTH-1:0] elem, a_elem, b_elem;
   logic [ADDR_WIDTH-1:0] a_rd_addr, b_rd_addr;
   beat_ctrl_type        ctrl_s0, ctrl_s2;
   logic signed [ACC_WIDTH-1:0] tail_re, tail_im;
   logic                 out_valid_ff, out_last_ff;
   logic signed [ACC_WIDTH-1:0] out_re_ff, out_im_ff;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_WIDTH'(MAX_DIM);
         inner_dim_ff <= DIM_WIDTH'(MAX_DIM);
         cols_b_ff    <= DIM_WIDTH'(MAX_DIM);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS_A:    rows_a_ff    <= csr_wr_data;
            CSR_INNER_DIM: inner_dim_ff <= csr_wr_data;
            CSR_COLS_B:    cols_b_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign m_dim = eff_dim(rows_a_ff);
   assign n_dim = eff_dim(inner_dim_ff);
   assign p_dim = eff_dim(cols_b_ff);
   assign mn    = CNT_WIDTH'(m_dim) * CNT_WIDTH'(n_dim);
   assign np    = CNT_WIDTH'(n_dim) * CNT_WIDTH'(p_dim);

   // Load counting; a stale B count restarts at zero, extra A beats drop
   assign req_chan.ready = !busy;
   assign accept  = req_chan.valid && req_chan.ready;
   assign a_wr    = accept && (func_type'(req_chan.func) == FUNC_LOAD_A) && (a_count_ff < mn);
   assign b_wr    = accept && (func_type'(req_chan.func) == FUNC_LOAD_B);
   assign b_idx   = (b_count_ff >= np) ? '0 : b_count_ff;
   assign b_next  = b_idx + CNT_WIDTH'(1);
   assign trigger = b_wr && (b_next == np);
   assign elem    = {req_chan.real_in, req_chan.imag_in};

   always_comb begin
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      if (a_wr) a_count_in = a_count_ff + CNT_WIDTH'(1);
      if (b_wr) b_count_in = trigger ? '0 : b_next;
      if (trigger) a_count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_count_ff <= '0;
         b_count_ff <= '0;
      end else begin
         a_count_ff <= a_count_in;
         b_count_ff <= b_count_in;
      end
   end

   // Whole pipeline holds while an entry waits for the output register
   assign en = !(ctrl_s2.valid && ctrl_s2.emit && out_valid_ff && !rsp_chan.ready);

   cmm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(STORE_DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr),
      .wr_addr (a_count_ff[ADDR_WIDTH-1:0]),
      .wr_data (elem),
      .rd_en   (en),
      .rd_addr (a_rd_addr),
      .rd_data (a_elem)
   );

   cmm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(STORE_DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (b_idx[ADDR_WIDTH-1:0]),
      .wr_data (elem),
      .rd_en   (en),
      .rd_addr (b_rd_addr),
      .rd_data (b_elem)
   );

   cmm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (trigger),
      .en     (en),
      .m_dim  (m_dim),
      .n_dim  (n_dim),
      .p_dim  (p_dim),
      .a_addr (a_rd_addr),
      .b_addr (b_rd_addr),
      .ctrl   (ctrl_s0),
      .busy   (busy)
   );

   cmm_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctrl_s0 (ctrl_s0),
      .a_elem  (a_elem),
      .b_elem  (b_elem),
      .p_dim   (p_dim),
      .ctrl_s2 (ctrl_s2),
      .tail_re (tail_re),
      .tail_im (tail_im)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en && ctrl_s2.valid && ctrl_s2.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en && ctrl_s2.valid && ctrl_s2.emit) begin
         out_re_ff   <= tail_re;
         out_im_ff   <= tail_im;
         out_last_ff <= ctrl_s2.last;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.real_out = out_re_ff;
   assign rsp_chan.imag_out = out_im_ff;
   assign rsp_chan.last     = out_last_ff;

endmodule

@@ sv/cmm_checker.sv @@
// ---------------------------------------------------------------------------
// cmm_checker
// Port-level checks of the complex matrix multiply unit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cmm_checker import cmm_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [ACC_WIDTH-1:0] rsp_real_out,
   input logic signed [ACC_WIDTH-1:0] rsp_imag_out,
   input logic                        rsp_last
);

   // Result beat and its payload stay put while the sink stalls
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_real_out)
         && $stable(rsp_imag_out) && $stable(rsp_last);
   endproperty

   // Load side closes only after a B beat was offered
   property p_busy_cause;
      $fell(req_ready) |-> $past(req_valid && req_func == FUNC_LOAD_B);
   endproperty

   // No entry shows right after reset
   `CMM_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid)

   // A stalled result beat holds
   `CMM_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold)

   // Loading stops only after a B beat was offered
   `CMM_ASSERT(a_busy_cause, clock, reset, p_busy_cause)

endmodule

bind complex_matrix_multiply_unit cmm_checker u_cmm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_real_out (rsp_chan.real_out),
   .rsp_imag_out (rsp_chan.imag_out),
   .rsp_last     (rsp_chan.last)
);
